>>> hdl/rcuf_pkg.sv
// Shared constants and types for the row/column union-find component counter.
// No dependencies; every other file of the block but rcuf_ram refers to it by scoped names.

package rcuf_pkg;

   // Input coordinate widths
   localparam int ROW_W = 10;
   localparam int COL_W = 10;

   // Node space: row nodes first, column nodes after them (both powers of two)
   localparam int ROW_NODES  = 1024;
   localparam int COL_NODES  = 1024;
   localparam int NODE_COUNT = ROW_NODES + COL_NODES;
   localparam int NODE_W     = $clog2(NODE_COUNT);

   // Rank of a tree root, saturating
   localparam int RANK_W   = 4;
   localparam int RANK_MAX = 15;

   // Point counter, saturating
   localparam int POINT_W   = 16;
   localparam int POINT_MAX = 65535;

   // Component counter is exact inside; the reported count saturates
   localparam int COMP_W        = $clog2(NODE_COUNT + 1);
   localparam int REMOVE_W      = 16;
   localparam int GROUP_W       = 12;
   localparam int GROUP_OUT_MAX = 4095;

   // One node entry in the disjoint-set store
   typedef struct packed {
      logic              touched;
      logic [RANK_W-1:0] rank;
      logic [NODE_W-1:0] parent;
   } node_word_type;

   localparam int WORD_W = $bits(node_word_type);

endpackage

>>> hdl/rcuf_chan_if.sv
// Valid/ready channel interfaces for the point stream and the result stream.
// Depends on rcuf_pkg for field widths.

interface rcuf_req_if;
   logic                         valid;
   logic                         ready;
   logic [rcuf_pkg::ROW_W-1:0]   row_index;
   logic [rcuf_pkg::COL_W-1:0]   col_index;
   logic                         last_point;

   modport source (output valid, row_index, col_index, last_point, input ready);
   modport sink   (input valid, row_index, col_index, last_point, output ready);
endinterface

interface rcuf_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [rcuf_pkg::REMOVE_W-1:0]  removable_count;
   logic [rcuf_pkg::GROUP_W-1:0]   group_count;

   modport source (output valid, removable_count, group_count, input ready);
   modport sink   (input valid, removable_count, group_count, output ready);
endinterface

>>> hdl/row_column_union_find_components.sv
// Top level of the row/column union-find component counter.
// Depends on rcuf_pkg, rcuf_req_if / rcuf_rsp_if and rcuf_ram.

// Each point joins its row node and its column node in one disjoint-set store
// (union by rank, path compression), held in a single RAM of parent, rank and
// touched bit per node. Each point walks from its row node and then from its column
// node up to the root, compresses the path when the start node is not the root,
// unites the two roots and, when a union of equal ranks raises a rank, writes the
// raised rank; the single RAM read port lets each walk visit one node per cycle.
// The point marked last produces one result, then the store is swept clean one
// node per cycle before the next point is taken; the same sweep runs after reset.
// The result waits in an output register and does not hold up the sweep.

module row_column_union_find_components (
   input  logic              clock,
   input  logic              reset,
   rcuf_req_if.sink          req_port,
   rcuf_rsp_if.source        rsp_port
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_WALK,
      S_COMP,
      S_UNION,
      S_BUMP,
      S_DONE
   } state_type;

   localparam logic [rcuf_pkg::NODE_W-1:0] LAST_NODE =
      rcuf_pkg::NODE_W'(rcuf_pkg::NODE_COUNT - 1);
   localparam logic [rcuf_pkg::RANK_W-1:0] RANK_TOP =
      rcuf_pkg::RANK_W'(rcuf_pkg::RANK_MAX);
   localparam logic [rcuf_pkg::POINT_W-1:0] POINT_TOP =
      rcuf_pkg::POINT_W'(rcuf_pkg::POINT_MAX);

   state_type                        state_ff, state_in;
   logic [rcuf_pkg::NODE_W-1:0]      start_ff, start_in;
   logic [rcuf_pkg::NODE_W-1:0]      walk_ff, walk_in;
   logic [rcuf_pkg::NODE_W-1:0]      node_v_ff, node_v_in;
   logic                             phase_ff, phase_in;
   logic                             last_ff, last_in;
   logic [rcuf_pkg::NODE_W-1:0]      root_a_ff, root_a_in;
   logic [rcuf_pkg::NODE_W-1:0]      root_b_ff, root_b_in;
   logic [rcuf_pkg::RANK_W-1:0]      rank_a_ff, rank_a_in;
   logic [rcuf_pkg::RANK_W-1:0]      rank_b_ff, rank_b_in;
   logic [rcuf_pkg::POINT_W-1:0]     point_ff, point_in;
   logic [rcuf_pkg::COMP_W-1:0]      comp_ff, comp_in;
   logic [rcuf_pkg::NODE_W-1:0]      clr_ff, clr_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [rcuf_pkg::REMOVE_W-1:0]    removable_ff, removable_in;
   logic [rcuf_pkg::GROUP_W-1:0]     group_ff, group_in;

   logic [rcuf_pkg::NODE_W-1:0]      node_u;
   logic [rcuf_pkg::NODE_W-1:0]      node_v;
   logic [rcuf_pkg::NODE_W-1:0]      cur_root;
   logic [rcuf_pkg::POINT_W-1:0]     point_sat;

   logic                             ram_we;
   logic [rcuf_pkg::NODE_W-1:0]      ram_waddr;
   rcuf_pkg::node_word_type          ram_wdata;
   logic [rcuf_pkg::NODE_W-1:0]      ram_raddr;
   logic [rcuf_pkg::WORD_W-1:0]      ram_rdata;
   rcuf_pkg::node_word_type          rd_word;

   // Map coordinates onto node numbers; the counts are powers of two
   assign node_u = rcuf_pkg::NODE_W'(32'(req_port.row_index) % rcuf_pkg::ROW_NODES);
   assign node_v = rcuf_pkg::NODE_W'(rcuf_pkg::ROW_NODES
                   + (32'(req_port.col_index) % rcuf_pkg::COL_NODES));

   assign rd_word   = rcuf_pkg::node_word_type'(ram_rdata);
   assign cur_root  = phase_ff ? root_b_ff : root_a_ff;
   assign point_sat = (point_ff == POINT_TOP) ? point_ff : point_ff + 1'b1;

   // Drive the channels
   assign req_port.ready           = (state_ff == S_IDLE);
   assign rsp_port.valid           = rsp_valid_ff;
   assign rsp_port.removable_count = removable_ff;
   assign rsp_port.group_count     = group_ff;

   // Disjoint-set store
   rcuf_ram #(
      .WIDTH (rcuf_pkg::WORD_W),
      .DEPTH (rcuf_pkg::NODE_COUNT)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Sequencer: next state, store access and counters
   always_comb begin
      state_in     = state_ff;
      start_in     = start_ff;
      walk_in      = walk_ff;
      node_v_in    = node_v_ff;
      phase_in     = phase_ff;
      last_in      = last_ff;
      root_a_in    = root_a_ff;
      root_b_in    = root_b_ff;
      rank_a_in    = rank_a_ff;
      rank_b_in    = rank_b_ff;
      point_in     = point_ff;
      comp_in      = comp_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff;
      removable_in = removable_ff;
      group_in     = group_ff;
      ram_we       = 1'b0;
      ram_waddr    = walk_ff;
      ram_wdata    = '0;
      ram_raddr    = walk_ff;

      // Drop the result once taken
      if (rsp_valid_ff && rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         // Sweep every node back to its own parent, rank zero, untouched
         S_CLEAR: begin
            ram_we           = 1'b1;
            ram_waddr        = clr_ff;
            ram_wdata.parent = clr_ff;
            clr_in           = clr_ff + 1'b1;
            point_in         = '0;
            comp_in          = '0;
            if (clr_ff == LAST_NODE) begin
               state_in = S_IDLE;
            end
         end

         // Take a point and start the root walk from the row node
         S_IDLE: begin
            ram_raddr = node_u;
            if (req_port.valid) begin
               start_in  = node_u;
               walk_in   = node_u;
               node_v_in = node_v;
               last_in   = req_port.last_point;
               phase_in  = 1'b0;
               state_in  = S_WALK;
            end
         end

         // Follow parents up to the root, marking the start node touched
         S_WALK: begin
            if (walk_ff == start_ff && !rd_word.touched) begin
               ram_we            = 1'b1;
               ram_waddr         = walk_ff;
               ram_wdata.touched = 1'b1;
               ram_wdata.rank    = rd_word.rank;
               ram_wdata.parent  = rd_word.parent;
               comp_in           = comp_ff + 1'b1;
            end
            if (rd_word.parent == walk_ff) begin
               if (phase_ff) begin
                  root_b_in = walk_ff;
                  rank_b_in = rd_word.rank;
               end else begin
                  root_a_in = walk_ff;
                  rank_a_in = rd_word.rank;
               end
               if (walk_ff == start_ff) begin
                  // start is the root: nothing to compress
                  if (!phase_ff) begin
                     phase_in  = 1'b1;
                     start_in  = node_v_ff;
                     walk_in   = node_v_ff;
                     ram_raddr = node_v_ff;
                  end else begin
                     state_in = S_UNION;
                  end
               end else begin
                  walk_in   = start_ff;
                  ram_raddr = start_ff;
                  state_in  = S_COMP;
               end
            end else begin
               walk_in   = rd_word.parent;
               ram_raddr = rd_word.parent;
            end
         end

         // Point every node on the path straight at the root
         S_COMP: begin
            if (walk_ff == cur_root) begin
               if (!phase_ff) begin
                  phase_in  = 1'b1;
                  start_in  = node_v_ff;
                  walk_in   = node_v_ff;
                  ram_raddr = node_v_ff;
                  state_in  = S_WALK;
               end else begin
                  state_in = S_UNION;
               end
            end else begin
               ram_we            = 1'b1;
               ram_waddr         = walk_ff;
               ram_wdata.touched = rd_word.touched;
               ram_wdata.rank    = rd_word.rank;
               ram_wdata.parent  = cur_root;
               walk_in           = rd_word.parent;
               ram_raddr         = rd_word.parent;
            end
         end

         // Hang the lower-ranked root under the other
         S_UNION: begin
            state_in = S_DONE;
            if (root_a_ff != root_b_ff) begin
               if (comp_ff != '0) begin
                  comp_in = comp_ff - 1'b1;
               end
               ram_we            = 1'b1;
               ram_wdata.touched = 1'b1;
               if (rank_a_ff < rank_b_ff) begin
                  ram_waddr        = root_a_ff;
                  ram_wdata.rank   = rank_a_ff;
                  ram_wdata.parent = root_b_ff;
               end else begin
                  ram_waddr        = root_b_ff;
                  ram_wdata.rank   = rank_b_ff;
                  ram_wdata.parent = root_a_ff;
                  if (rank_a_ff == rank_b_ff && rank_a_ff < RANK_TOP) begin
                     state_in = S_BUMP;
                  end
               end
            end
         end

         // Raise the rank of the surviving root after an even union
         S_BUMP: begin
            ram_we            = 1'b1;
            ram_waddr         = root_a_ff;
            ram_wdata.touched = 1'b1;
            ram_wdata.rank    = rank_a_ff + 1'b1;
            ram_wdata.parent  = root_a_ff;
            state_in          = S_DONE;
         end

         // Count the point; on the last one report and clear
         S_DONE: begin
            if (!last_ff) begin
               point_in = point_sat;
               state_in = S_IDLE;
            end else if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in = 1'b1;
               removable_in = (32'(point_sat) > 32'(comp_ff))
                              ? rcuf_pkg::REMOVE_W'(32'(point_sat) - 32'(comp_ff))
                              : '0;
               group_in     = (32'(comp_ff) > rcuf_pkg::GROUP_OUT_MAX)
                              ? rcuf_pkg::GROUP_W'(rcuf_pkg::GROUP_OUT_MAX)
                              : rcuf_pkg::GROUP_W'(comp_ff);
               clr_in       = '0;
               state_in     = S_CLEAR;
            end
         end

         default: begin
            state_in = S_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         phase_ff     <= 1'b0;
         last_ff      <= 1'b0;
         point_ff     <= '0;
         comp_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         phase_ff     <= phase_in;
         last_ff      <= last_in;
         point_ff     <= point_in;
         comp_ff      <= comp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      start_ff     <= start_in;
      walk_ff      <= walk_in;
      node_v_ff    <= node_v_in;
      root_a_ff    <= root_a_in;
      root_b_ff    <= root_b_in;
      rank_a_ff    <= rank_a_in;
      rank_b_ff    <= rank_b_in;
      removable_ff <= removable_in;
      group_ff     <= group_in;
   end

endmodule

>>> hdl/rcuf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module rcuf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port, and read data registered every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> hdl/rcuf_checker.sv
// Port-level checks for the row/column union-find component counter, bound
// to the top level. Depends on rcuf_pkg.

module rcuf_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [rcuf_pkg::REMOVE_W-1:0]   removable_count,
   input logic [rcuf_pkg::GROUP_W-1:0]    group_count
);

   // The store is swept right after reset, so no item is taken then
   a_sweep_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_ready)
      else $error("item taken during the clearing sweep after reset");

   // One item at a time: ready drops after an item is taken
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready stayed high after an item was taken");

   // Components never outnumber the nodes
   a_group_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(group_count) <= rcuf_pkg::NODE_COUNT))
      else $error("group count exceeds node count");

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(removable_count) && $stable(group_count)))
      else $error("result changed while stalled");

endmodule

bind row_column_union_find_components rcuf_checker u_rcuf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_port.valid),
   .req_ready       (req_port.ready),
   .rsp_valid       (rsp_port.valid),
   .rsp_ready       (rsp_port.ready),
   .removable_count (rsp_port.removable_count),
   .group_count     (rsp_port.group_count)
);

>>> tb/tb_row_column_union_find_components.sv
`timescale 1ns / 100ps
// Self-checking testbench for row_column_union_find_components: point sets in, tallies out.
// Depends on rcuf_pkg, rcuf_req_if / rcuf_rsp_if and the block's top level.

module tb_row_column_union_find_components;

   localparam int RANDOM_ITEMS = 550;
   localparam int LONG_HOLD = 9000;
   localparam int SETTLE_CYCLES = rcuf_pkg::NODE_COUNT + 200;
   localparam int CYCLE_LIMIT = 6000000;

   typedef struct packed {
      logic [rcuf_pkg::REMOVE_W-1:0] removable;
      logic [rcuf_pkg::GROUP_W-1:0]  groups;
   } tally_type;

   typedef struct packed {
      logic [rcuf_pkg::ROW_W-1:0]    row;
      logic [rcuf_pkg::COL_W-1:0]    col;
      logic                          last;
      logic                          pinned;
      logic [rcuf_pkg::REMOVE_W-1:0] removable;
      logic [rcuf_pkg::GROUP_W-1:0]  groups;
   } seed_row_type;

   typedef enum {SET_SCATTER, SET_CLUSTER, SET_STAIR, SET_DENSE} set_kind_type;
   typedef enum {RSP_OPEN, RSP_PATTERN, RSP_COIN} rsp_mode_type;

   // Directed sets; pinned rows carry a tally that can be read off directly
   localparam int SEED_COUNT = 22;
   localparam seed_row_type SEED_ROWS [SEED_COUNT] = '{
      // lone point at the low corner, then at the high corner
      '{10'd0,    10'd0,    1'b1, 1'b1, 16'd0, 12'd1},
      '{10'd1023, 10'd1023, 1'b1, 1'b1, 16'd0, 12'd1},
      // repeated point
      '{10'd5,    10'd5,    1'b0, 1'b0, 16'd0, 12'd0},
      '{10'd5,    10'd5,    1'b1, 1'b1, 16'd1, 12'd1},
      // two unrelated points: nothing removable
      '{10'd1,    10'd2,    1'b0, 1'b0, 16'd0, 12'd0},
      '{10'd3,    10'd4,    1'b1, 1'b1, 16'd0, 12'd2},
      // four corners closing into one group
      '{10'd0,    10'd1023, 1'b0, 1'b0, 16'd0, 12'd0},
      '{10'd1023, 10'd0,    1'b0, 1'b0, 16'd0, 12'd0},
      '{10'd0,    10'd0,    1'b0, 1'b0, 16'd0, 12'd0},
      '{10'd1023, 10'd1023, 1'b1, 1'b1, 16'd3, 12'd1},
      // staircase chain
      '{10'd10,   10'd10,   1'b0, 1'b0, 16'd0, 12'd0},
      '{10'd11,   10'd10,   1'b0, 1'b0, 16'd0, 12'd0},
      '{10'd11,   10'd11,   1'b0, 1'b0, 16'd0, 12'd0},
      '{10'd12,   10'd11,   1'b0, 1'b0, 16'd0, 12'd0},
      '{10'd12,   10'd12,   1'b0, 1'b0, 16'd0, 12'd0},
      '{10'd13,   10'd12,   1'b1, 1'b0, 16'd0, 12'd0},
      // alternating bit patterns
      '{10'd682,  10'd341,  1'b0, 1'b0, 16'd0, 12'd0},
      '{10'd341,  10'd682,  1'b1, 1'b1, 16'd0, 12'd2},
      // two pairs merged into one tree
      '{10'd20,   10'd20,   1'b0, 1'b0, 16'd0, 12'd0},
      '{10'd21,   10'd21,   1'b0, 1'b0, 16'd0, 12'd0},
      '{10'd20,   10'd21,   1'b0, 1'b0, 16'd0, 12'd0},
      '{10'd21,   10'd20,   1'b1, 1'b0, 16'd0, 12'd0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   rcuf_req_if point_bus ();
   rcuf_rsp_if tally_bus ();

   row_column_union_find_components uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (point_bus),
      .rsp_port (tally_bus)
   );

   always #5 clock = ~clock;

   // Predicted disjoint-set store
   logic [rcuf_pkg::NODE_W-1:0] parent_tbl [rcuf_pkg::NODE_COUNT];
   logic [rcuf_pkg::RANK_W-1:0] rank_tbl [rcuf_pkg::NODE_COUNT];
   bit                          touched_tbl [rcuf_pkg::NODE_COUNT];
   int unsigned                 point_total;
   int unsigned                 group_total;

   tally_type expected_tallies [$];
   tally_type want;
   int        fault_count = 0;
   int        cycle_count = 0;
   bit        offering = 1'b0;
   bit        steady = 1'b0;
   int        burst_left = 1;

   function automatic void clear_store();
      for (int i = 0; i < rcuf_pkg::NODE_COUNT; i++) begin
         parent_tbl[i] = rcuf_pkg::NODE_W'(i);
         rank_tbl[i] = '0;
         touched_tbl[i] = 1'b0;
      end
      point_total = 0;
      group_total = 0;
   endfunction

   // Find the root and point every node on the way straight at it
   function automatic logic [rcuf_pkg::NODE_W-1:0] root_of(
      input logic [rcuf_pkg::NODE_W-1:0] node);
      logic [rcuf_pkg::NODE_W-1:0] root;
      logic [rcuf_pkg::NODE_W-1:0] cur;
      logic [rcuf_pkg::NODE_W-1:0] nxt;
      root = node;
      while (parent_tbl[root] != root) root = parent_tbl[root];
      cur = node;
      while (cur != root) begin
         nxt = parent_tbl[cur];
         parent_tbl[cur] = root;
         cur = nxt;
      end
      return root;
   endfunction

   function automatic void mark_node(input logic [rcuf_pkg::NODE_W-1:0] node);
      if (!touched_tbl[node]) begin
         touched_tbl[node] = 1'b1;
         group_total++;
      end
   endfunction

   function automatic void unite_nodes(input logic [rcuf_pkg::NODE_W-1:0] a,
                                       input logic [rcuf_pkg::NODE_W-1:0] b);
      logic [rcuf_pkg::NODE_W-1:0] ra;
      logic [rcuf_pkg::NODE_W-1:0] rb;
      ra = root_of(a);
      rb = root_of(b);
      if (ra == rb) return;
      if (rank_tbl[ra] < rank_tbl[rb]) begin
         parent_tbl[ra] = rb;
      end else if (rank_tbl[rb] < rank_tbl[ra]) begin
         parent_tbl[rb] = ra;
      end else begin
         parent_tbl[rb] = ra;
         if (rank_tbl[ra] < rcuf_pkg::RANK_W'(rcuf_pkg::RANK_MAX)) rank_tbl[ra]++;
      end
      if (group_total > 0) group_total--;
   endfunction

   // Fold one point into the store; a last point yields its tally and clears
   function automatic bit tally_point(input logic [rcuf_pkg::ROW_W-1:0] row,
                                      input logic [rcuf_pkg::COL_W-1:0] col,
                                      input logic last, output tally_type tally);
      logic [rcuf_pkg::NODE_W-1:0] u;
      logic [rcuf_pkg::NODE_W-1:0] v;
      u = rcuf_pkg::NODE_W'(row % rcuf_pkg::ROW_NODES);
      v = rcuf_pkg::NODE_W'(rcuf_pkg::ROW_NODES + (col % rcuf_pkg::COL_NODES));
      tally = '0;
      mark_node(u);
      mark_node(v);
      unite_nodes(u, v);
      if (point_total < rcuf_pkg::POINT_MAX) point_total++;
      if (!last) return 1'b0;
      tally.removable = (point_total > group_total)
                        ? rcuf_pkg::REMOVE_W'(point_total - group_total) : '0;
      tally.groups = (group_total > rcuf_pkg::GROUP_OUT_MAX)
                     ? rcuf_pkg::GROUP_W'(rcuf_pkg::GROUP_OUT_MAX)
                     : rcuf_pkg::GROUP_W'(group_total);
      clear_store();
      return 1'b1;
   endfunction

   // Space items into bursts with random gaps unless running flat out
   task automatic pace_sender();
      if (steady) return;
      if (burst_left > 1) begin
         burst_left--;
      end else begin
         point_bus.valid <= 1'b0;
         offering = 1'b0;
         if ($urandom_range(0, 7) == 0) repeat ($urandom_range(20, 60)) @(posedge clock);
         else repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
      end
   endtask

   task automatic offer_point(input logic [rcuf_pkg::ROW_W-1:0] row,
                              input logic [rcuf_pkg::COL_W-1:0] col,
                              input logic last, input bit pinned,
                              input tally_type pinned_tally);
      tally_type predicted;
      bit        has_tally;
      point_bus.valid <= 1'b1;
      point_bus.row_index <= row;
      point_bus.col_index <= col;
      point_bus.last_point <= last;
      offering = 1'b1;
      do @(posedge clock); while (!point_bus.ready);
      has_tally = tally_point(row, col, last, predicted);
      if (has_tally) expected_tallies.push_back(pinned ? pinned_tally : predicted);
      pace_sender();
   endtask

   // Hold the sender until every expected tally has come back
   task automatic drain_tallies();
      if (offering) begin
         point_bus.valid <= 1'b0;
         offering = 1'b0;
      end
      while (expected_tallies.size() != 0) @(posedge clock);
   endtask

   task automatic play_random_set(input int points, input set_kind_type kind);
      logic [rcuf_pkg::ROW_W-1:0] base_r;
      logic [rcuf_pkg::COL_W-1:0] base_c;
      logic [rcuf_pkg::ROW_W-1:0] row;
      logic [rcuf_pkg::COL_W-1:0] col;
      int                         span;
      base_r = rcuf_pkg::ROW_W'($urandom);
      base_c = rcuf_pkg::COL_W'($urandom);
      span = (kind == SET_DENSE) ? $urandom_range(1, 3) : (1 << $urandom_range(1, 4));
      for (int i = 0; i < points; i++) begin
         case (kind)
            SET_SCATTER: begin
               row = rcuf_pkg::ROW_W'($urandom_range(0, 1023));
               col = rcuf_pkg::COL_W'($urandom_range(0, 1023));
            end
            SET_STAIR: begin
               row = base_r + rcuf_pkg::ROW_W'((i + 1) >> 1);
               col = base_c + rcuf_pkg::COL_W'(i >> 1);
               if ($urandom_range(0, 7) == 0) row = rcuf_pkg::ROW_W'($urandom);
            end
            default: begin
               row = base_r + rcuf_pkg::ROW_W'($urandom_range(0, span - 1));
               col = base_c + rcuf_pkg::COL_W'($urandom_range(0, span - 1));
            end
         endcase
         offer_point(row, col, i == points - 1, 1'b0, '0);
      end
   endtask

   // Check each tally against the oldest expectation
   always @(posedge clock) begin
      if (!reset && tally_bus.valid && tally_bus.ready) begin
         if (expected_tallies.size() == 0) begin
            $error("unexpected tally: removable_count %0d, group_count %0d",
                   tally_bus.removable_count, tally_bus.group_count);
            fault_count++;
         end else begin
            want = expected_tallies.pop_front();
            if (tally_bus.removable_count !== want.removable) begin
               $error("removable_count: expected %0d, actual %0d",
                      want.removable, tally_bus.removable_count);
               fault_count++;
            end
            if (tally_bus.group_count !== want.groups) begin
               $error("group_count: expected %0d, actual %0d", want.groups, tally_bus.group_count);
               fault_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("row_column_union_find_components test failed");
         $finish;
      end
   end

   // Tally receiver: stretches of open, patterned and coin-flip ready, one long hold
   initial begin
      rsp_mode_type mode;
      int           stretch;
      int           taken;
      bit           held;
      logic [7:0]   pattern;
      mode = RSP_OPEN;
      stretch = 0;
      taken = 0;
      held = 1'b0;
      pattern = 8'hFF;
      tally_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (tally_bus.valid && tally_bus.ready) taken++;
         if (!held && taken == 12) begin
            held = 1'b1;
            tally_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            if (stretch == 0) begin
               mode = rsp_mode_type'($urandom_range(0, 2));
               stretch = $urandom_range(8, 64);
               pattern = 8'($urandom);
            end
            stretch--;
            case (mode)
               RSP_OPEN: tally_bus.ready <= 1'b1;
               RSP_PATTERN: begin
                  tally_bus.ready <= pattern[0];
                  pattern = {pattern[0], pattern[7:1]};
               end
               default: tally_bus.ready <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // Stimulus
   initial begin
      int        random_items;
      int        points;
      bit        paused;
      tally_type pinned_tally;
      point_bus.valid <= 1'b0;
      point_bus.row_index <= '0;
      point_bus.col_index <= '0;
      point_bus.last_point <= 1'b0;
      clear_store();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed sets
      for (int i = 0; i < SEED_COUNT; i++) begin
         pinned_tally.removable = SEED_ROWS[i].removable;
         pinned_tally.groups = SEED_ROWS[i].groups;
         offer_point(SEED_ROWS[i].row, SEED_ROWS[i].col, SEED_ROWS[i].last,
                     SEED_ROWS[i].pinned, pinned_tally);
      end

      // random sets, mostly small, some clustered to force deep merges
      random_items = 0;
      paused = 1'b0;
      while (random_items < RANDOM_ITEMS) begin
         points = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
         play_random_set(points, set_kind_type'($urandom_range(0, 3)));
         random_items += points;
         if (!paused && random_items >= RANDOM_ITEMS / 2) begin
            paused = 1'b1;
            drain_tallies();
         end
      end

      // wait out the last tally and the clearing sweep behind it
      drain_tallies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("row_column_union_find_components test passed");
      end else begin
         $display("row_column_union_find_components test failed");
      end
      $finish;
   end

endmodule
